// ===== rtl/gjls_pkg.sv =====
package gjls_pkg;

	localparam int MAX_EQUATIONS_DEF = 8;
	localparam int MAX_VARIABLES_DEF = 8;

	localparam int WORD_W = 48;
	localparam int VALUE_W = 32;

	localparam logic [47:0] MAG_MAX = 48'h7FFF_FFFF_FFFF;

	// register indexes of the configuration port
	localparam logic [1:0] REG_NUM_EQUATIONS = 2'd0;
	localparam logic [1:0] REG_NUM_VARIABLES = 2'd1;
	localparam logic [1:0] REG_PIVOT_TOL = 2'd2;
	localparam logic [1:0] REG_RESIDUAL_TOL = 2'd3;

	// system status codes
	localparam logic [1:0] STATUS_NONE = 2'd0;
	localparam logic [1:0] STATUS_UNIQUE = 2'd1;
	localparam logic [1:0] STATUS_INFINITE = 2'd2;

	// arithmetic unit operations
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	typedef struct packed {
		logic start;
		logic op;
		logic signed [47:0] a;
		logic signed [47:0] b;
	} md_req_t;

	typedef struct packed {
		logic done;
		logic signed [47:0] result;
	} md_rsp_t;

	function automatic logic [47:0] mag48(input logic signed [47:0] v);
		return v[47] ? (~v + 48'd1) : v;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		if (!v[48] && v[47]) begin
			return MAG_MAX;
		end
		if (v[48] && (!v[47] || (v[46:0] == 47'd0))) begin
			return ~MAG_MAX + 48'd1;
		end
		return v[47:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if ((v[47:31] != {17{1'b0}}) && (v[47:31] != {17{1'b1}})) begin
			return v[47] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return v[31:0];
	endfunction

endpackage

// ===== rtl/gjls_ram.sv =====
module gjls_ram #(
	parameter int W = 48,
	parameter int D = 72,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/gjls_muldiv.sv =====
// Shared multi-cycle unit: Q16 multiply in three 48x16 partial products,
// Q16 divide by restoring division, one quotient bit a cycle.
module gjls_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  gjls_pkg::md_req_t req,
	output gjls_pkg::md_rsp_t rsp
);

	localparam logic [6:0] MUL_LAST = 7'd2;
	localparam logic [6:0] DIV_LAST = 7'd63;

	logic        busy_q, fin_q, done_q;
	logic        op_q, neg_q;
	logic [6:0]  cnt_q;
	logic [47:0] ua_q, ub_q;
	logic [95:0] acc_q;
	logic [63:0] num_q, quo_q;
	logic [48:0] rem_q;
	logic signed [47:0] res_q;

	logic [63:0] partial;
	logic [48:0] rem_sh, rem_nx;
	logic        ge, last;
	logic [47:0] mag_r;

	assign partial = ua_q * ub_q[47:32];
	assign rem_sh = {rem_q[47:0], num_q[63]};
	assign ge = rem_sh >= {1'b0, ub_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, ub_q}) : rem_sh;
	assign last = (op_q == gjls_pkg::OP_MUL) ? (cnt_q == MUL_LAST) : (cnt_q == DIV_LAST);

	always_comb begin
		if (op_q == gjls_pkg::OP_MUL) begin
			mag_r = (|acc_q[95:63]) ? gjls_pkg::MAG_MAX : acc_q[63:16];
		end else if (ub_q == 48'd0) begin
			mag_r = 48'd0;
		end else begin
			mag_r = (|quo_q[63:47]) ? gjls_pkg::MAG_MAX : quo_q[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (op_q == gjls_pkg::OP_MUL) begin
					acc_q <= {acc_q[79:0], 16'd0} + {32'd0, partial};
					ub_q <= {ub_q[31:0], 16'd0};
				end else begin
					rem_q <= rem_nx;
					num_q <= {num_q[62:0], 1'b0};
					quo_q <= {quo_q[62:0], ge};
				end
				if (last) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				neg_q <= req.a[47] ^ req.b[47];
				ua_q <= gjls_pkg::mag48(req.a);
				ub_q <= gjls_pkg::mag48(req.b);
				cnt_q <= 7'd0;
				acc_q <= 96'd0;
				num_q <= {gjls_pkg::mag48(req.a), 16'd0};
				rem_q <= 49'd0;
				quo_q <= 64'd0;
			end
			if (fin_q) begin
				res_q <= neg_q ? (~mag_r + 48'd1) : mag_r;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.result = res_q;

endmodule

// ===== rtl/gauss_jordan_linear_solver_unit.sv =====
// Gauss-Jordan solver with partial pivoting on a signed Q16.16 augmented
// matrix. Load one element per cycle with start high while busy is low;
// the element marked load_done is stored too and starts the solve, after
// which busy stays high until the last result has been shown. A solve
// copies the loaded matrix into a working memory (MAX_EQUATIONS x
// 2^ceil(log2(MAX_VARIABLES+1)) entries, one a cycle), then eliminates
// column by column: the pivot search reads and compares each remaining
// row in turn, each eliminated row needs a divide and then, for each
// column from the pivot column to the right-hand side, two reads, a
// multiply and a write (one working-memory read port and one shared
// multiply/divide unit serve all of these), back substitution needs one
// divide per pivot, and the residual check one multiply per coefficient.
// Results then come one per variable, each on the result ports for
// exactly one cycle marked by result_valid; the receiver cannot stall
// them, so take each request as it comes. last_of_run marks the final
// variable. Write configuration only while busy is low; cfg_ready is
// always high.
module gauss_jordan_linear_solver_unit #(
	parameter int MAX_EQUATIONS = gjls_pkg::MAX_EQUATIONS_DEF,
	parameter int MAX_VARIABLES = gjls_pkg::MAX_VARIABLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  element_row,
	input  logic [3:0]  element_col,
	input  logic signed [31:0] element_value,
	input  logic        load_done,
	output logic        result_valid,
	output logic [2:0]  variable_index,
	output logic signed [31:0] solution_value,
	output logic [1:0]  system_status,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int ME = MAX_EQUATIONS;
	localparam int MV = MAX_VARIABLES;
	localparam int NW = $clog2(ME + 1);
	localparam int RW = (ME > 1) ? $clog2(ME) : 1;
	localparam int CW = $clog2(MV + 1);
	localparam int XW = (MV > 1) ? $clog2(MV) : 1;
	localparam int AW = RW + CW;
	localparam int DEPTH = ME * (2 ** CW);
	localparam int XD_W = RW + 32;

	localparam logic [5:0] S_IDLE   = 6'd0;
	localparam logic [5:0] S_COPY   = 6'd1;
	localparam logic [5:0] S_COPYW  = 6'd2;
	localparam logic [5:0] S_COLCHK = 6'd3;
	localparam logic [5:0] S_SR_RD  = 6'd4;
	localparam logic [5:0] S_SR_US  = 6'd5;
	localparam logic [5:0] S_PV_CHK = 6'd6;
	localparam logic [5:0] S_SW_RA  = 6'd7;
	localparam logic [5:0] S_SW_RB  = 6'd8;
	localparam logic [5:0] S_SW_WA  = 6'd9;
	localparam logic [5:0] S_SW_WB  = 6'd10;
	localparam logic [5:0] S_PIV_RD = 6'd11;
	localparam logic [5:0] S_PIV_US = 6'd12;
	localparam logic [5:0] S_EL_CHK = 6'd13;
	localparam logic [5:0] S_EL_DIV = 6'd14;
	localparam logic [5:0] S_EL_DW  = 6'd15;
	localparam logic [5:0] S_EL_RA  = 6'd16;
	localparam logic [5:0] S_EL_RB  = 6'd17;
	localparam logic [5:0] S_EL_MUL = 6'd18;
	localparam logic [5:0] S_EL_MW  = 6'd19;
	localparam logic [5:0] S_BS_CHK = 6'd20;
	localparam logic [5:0] S_BS_AX  = 6'd21;
	localparam logic [5:0] S_BS_RB  = 6'd22;
	localparam logic [5:0] S_BS_DIV = 6'd23;
	localparam logic [5:0] S_BS_DW  = 6'd24;
	localparam logic [5:0] S_RS_ROW = 6'd25;
	localparam logic [5:0] S_RS_RD  = 6'd26;
	localparam logic [5:0] S_RS_MUL = 6'd27;
	localparam logic [5:0] S_RS_MW  = 6'd28;
	localparam logic [5:0] S_RS_RHS = 6'd29;
	localparam logic [5:0] S_RS_FIN = 6'd30;
	localparam logic [5:0] S_OUT_RD = 6'd31;
	localparam logic [5:0] S_OUT_EM = 6'd32;

	function automatic logic [AW-1:0] waddr_of(input logic [NW-1:0] r, input logic [CW-1:0] c);
		return {r[RW-1:0], c};
	endfunction

	// configuration
	logic [3:0]  num_eq_q, num_var_q;
	logic [15:0] ptol_q, rtol_q;

	// sequencer
	logic [5:0]    state_q;
	logic [NW-1:0] n_q, row_q, i_q, sel_q;
	logic [CW-1:0] m_q, col_q, j_q;
	logic [AW-1:0] cp_q, cp_addr_s1;
	logic          cp_vld_s1;
	logic [47:0]   best_q;
	logic signed [47:0] tmp_q, tmp2_q, piv_q, c_q, sum_q;
	logic [RW-1:0] prow_q;
	logic [MV-1:0] pv_q;
	logic [1:0]    status_q;

	// memories
	logic          st_we;
	logic [AW-1:0] st_waddr;
	logic [31:0]   st_rdata;
	logic          w_we;
	logic [AW-1:0] w_waddr, w_raddr;
	logic signed [47:0] w_wdata, w_rdata;
	logic          x_we;
	logic [XW-1:0] x_waddr, x_raddr;
	logic [XD_W-1:0] x_wdata, x_rdata;

	gjls_pkg::md_req_t md_req;
	gjls_pkg::md_rsp_t md_rsp;

	logic          accept, in_range;
	logic [NW-1:0] n_clamp;
	logic [CW-1:0] m_clamp;
	logic [47:0]   mg;
	logic signed [47:0] elim_res, sum_nx;
	logic signed [48:0] diff;
	logic [48:0]   diff_mag;
	logic [MV-1:0] m_mask;
	logic          pv_skip;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_range = (32'(element_row) < ME) && (32'(element_col) <= MV);

	// clamp the counts into their legal ranges when the solve starts
	always_comb begin
		if (num_eq_q == 4'd0) begin
			n_clamp = NW'(1);
		end else if (32'(num_eq_q) > ME) begin
			n_clamp = NW'(ME);
		end else begin
			n_clamp = NW'(num_eq_q);
		end
		if (num_var_q == 4'd0) begin
			m_clamp = CW'(1);
		end else if (32'(num_var_q) > MV) begin
			m_clamp = CW'(MV);
		end else begin
			m_clamp = CW'(num_var_q);
		end
	end

	always_comb begin
		for (int k = 0; k < MV; k++) begin
			m_mask[k] = (k < 32'(m_q));
		end
	end

	assign mg = gjls_pkg::mag48(w_rdata);
	assign pv_skip = (best_q == 48'd0) || (best_q < {32'd0, ptol_q});
	assign elim_res = gjls_pkg::sat48({tmp2_q[47], tmp2_q} - {md_rsp.result[47], md_rsp.result});
	assign sum_nx = gjls_pkg::sat48({sum_q[47], sum_q} + {md_rsp.result[47], md_rsp.result});
	assign diff = {sum_q[47], sum_q} - {w_rdata[47], w_rdata};
	assign diff_mag = diff[48] ? (~diff + 49'd1) : diff;

	// memory ports and arithmetic requests
	always_comb begin
		st_we = accept && in_range;
		st_waddr = {RW'(element_row), CW'(element_col)};
		w_we = 1'b0;
		w_waddr = cp_addr_s1;
		w_wdata = {{16{st_rdata[31]}}, st_rdata};
		w_raddr = waddr_of(row_q, col_q);
		x_we = 1'b0;
		x_waddr = col_q[XW-1:0];
		x_wdata = {prow_q, 32'd0};
		x_raddr = col_q[XW-1:0];
		md_req.start = 1'b0;
		md_req.op = gjls_pkg::OP_MUL;
		md_req.a = tmp_q;
		md_req.b = c_q;
		if (cp_vld_s1) begin
			w_we = 1'b1;
		end
		case (state_q)
			S_SR_RD: w_raddr = waddr_of(i_q, col_q);
			S_PV_CHK: begin
				x_we = !pv_skip;
				x_wdata = {row_q[RW-1:0], 32'd0};
			end
			S_SW_RA: w_raddr = waddr_of(sel_q, j_q);
			S_SW_RB: w_raddr = waddr_of(row_q, j_q);
			S_SW_WA: begin
				w_we = 1'b1;
				w_waddr = waddr_of(sel_q, j_q);
				w_wdata = w_rdata;
			end
			S_SW_WB: begin
				w_we = 1'b1;
				w_waddr = waddr_of(row_q, j_q);
				w_wdata = tmp_q;
			end
			S_PIV_RD: w_raddr = waddr_of(row_q, col_q);
			S_EL_CHK: w_raddr = waddr_of(i_q, col_q);
			S_EL_DIV: begin
				md_req.start = 1'b1;
				md_req.op = gjls_pkg::OP_DIV;
				md_req.a = w_rdata;
				md_req.b = piv_q;
			end
			S_EL_RA: w_raddr = waddr_of(row_q, j_q);
			S_EL_RB: w_raddr = waddr_of(i_q, j_q);
			S_EL_MUL: md_req.start = 1'b1;
			S_EL_MW: begin
				w_we = md_rsp.done;
				w_waddr = waddr_of(i_q, j_q);
				w_wdata = elim_res;
			end
			S_BS_CHK: begin
				x_we = (col_q != m_q) && !pv_q[col_q[XW-1:0]];
				x_wdata = {RW'(0), 32'd0};
			end
			S_BS_AX: w_raddr = {x_rdata[XD_W-1:32], m_q};
			S_BS_RB: w_raddr = {prow_q, col_q};
			S_BS_DIV: begin
				md_req.start = 1'b1;
				md_req.op = gjls_pkg::OP_DIV;
				md_req.a = tmp_q;
				md_req.b = w_rdata;
			end
			S_BS_DW: begin
				x_we = md_rsp.done;
				x_wdata = {prow_q, gjls_pkg::sat32(md_rsp.result)};
			end
			S_RS_RD: begin
				x_raddr = j_q[XW-1:0];
				w_raddr = waddr_of(i_q, j_q);
				if (j_q == m_q) begin
					w_raddr = waddr_of(i_q, m_q);
				end
			end
			S_RS_MUL: begin
				md_req.start = 1'b1;
				md_req.a = {{16{x_rdata[31]}}, x_rdata[31:0]};
				md_req.b = w_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_eq_q <= 4'd4;
			num_var_q <= 4'd3;
			ptol_q <= 16'd1;
			rtol_q <= 16'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gjls_pkg::REG_NUM_EQUATIONS: num_eq_q <= cfg_data[3:0];
				gjls_pkg::REG_NUM_VARIABLES: num_var_q <= cfg_data[3:0];
				gjls_pkg::REG_PIVOT_TOL: ptol_q <= cfg_data;
				gjls_pkg::REG_RESIDUAL_TOL: rtol_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cp_vld_s1 <= 1'b0;
			pv_q <= '0;
		end else begin
			cp_vld_s1 <= (state_q == S_COPY);
			cp_addr_s1 <= cp_q;
			case (state_q)
				S_IDLE: begin
					if (accept && load_done) begin
						n_q <= n_clamp;
						m_q <= m_clamp;
						cp_q <= '0;
						state_q <= S_COPY;
					end
				end
				// sweep the loaded matrix into the working memory
				S_COPY: begin
					cp_q <= cp_q + AW'(1);
					if (cp_q == AW'(DEPTH - 1)) begin
						state_q <= S_COPYW;
					end
				end
				S_COPYW: begin
					row_q <= '0;
					col_q <= '0;
					pv_q <= '0;
					state_q <= S_COLCHK;
				end
				S_COLCHK: begin
					if ((col_q < m_q) && (row_q < n_q)) begin
						i_q <= row_q;
						sel_q <= row_q;
						best_q <= 48'd0;
						state_q <= S_SR_RD;
					end else begin
						col_q <= '0;
						state_q <= S_BS_CHK;
					end
				end
				S_SR_RD: state_q <= S_SR_US;
				// strictly greater, so the first largest row wins
				S_SR_US: begin
					if (mg > best_q) begin
						best_q <= mg;
						sel_q <= i_q;
					end
					i_q <= i_q + NW'(1);
					state_q <= ((i_q + NW'(1)) < n_q) ? S_SR_RD : S_PV_CHK;
				end
				S_PV_CHK: begin
					if (pv_skip) begin
						col_q <= col_q + CW'(1);
						state_q <= S_COLCHK;
					end else begin
						pv_q[col_q[XW-1:0]] <= 1'b1;
						j_q <= col_q;
						state_q <= (sel_q != row_q) ? S_SW_RA : S_PIV_RD;
					end
				end
				S_SW_RA: state_q <= S_SW_RB;
				S_SW_RB: begin
					tmp_q <= w_rdata;
					state_q <= S_SW_WA;
				end
				S_SW_WA: state_q <= S_SW_WB;
				S_SW_WB: begin
					if (j_q == m_q) begin
						state_q <= S_PIV_RD;
					end else begin
						j_q <= j_q + CW'(1);
						state_q <= S_SW_RA;
					end
				end
				S_PIV_RD: state_q <= S_PIV_US;
				S_PIV_US: begin
					piv_q <= w_rdata;
					i_q <= '0;
					state_q <= S_EL_CHK;
				end
				S_EL_CHK: begin
					if (i_q == n_q) begin
						row_q <= row_q + NW'(1);
						col_q <= col_q + CW'(1);
						state_q <= S_COLCHK;
					end else if (i_q == row_q) begin
						i_q <= i_q + NW'(1);
					end else begin
						state_q <= S_EL_DIV;
					end
				end
				S_EL_DIV: state_q <= S_EL_DW;
				S_EL_DW: begin
					if (md_rsp.done) begin
						c_q <= md_rsp.result;
						j_q <= col_q;
						state_q <= S_EL_RA;
					end
				end
				S_EL_RA: state_q <= S_EL_RB;
				S_EL_RB: begin
					tmp_q <= w_rdata;
					state_q <= S_EL_MUL;
				end
				S_EL_MUL: begin
					tmp2_q <= w_rdata;
					state_q <= S_EL_MW;
				end
				S_EL_MW: begin
					if (md_rsp.done) begin
						if (j_q == m_q) begin
							i_q <= i_q + NW'(1);
							state_q <= S_EL_CHK;
						end else begin
							j_q <= j_q + CW'(1);
							state_q <= S_EL_RA;
						end
					end
				end
				// back substitution; free variables are written as zero
				S_BS_CHK: begin
					if (col_q == m_q) begin
						i_q <= '0;
						state_q <= S_RS_ROW;
					end else if (pv_q[col_q[XW-1:0]]) begin
						state_q <= S_BS_AX;
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				S_BS_AX: begin
					prow_q <= x_rdata[XD_W-1:32];
					state_q <= S_BS_RB;
				end
				S_BS_RB: begin
					tmp_q <= w_rdata;
					state_q <= S_BS_DIV;
				end
				S_BS_DIV: state_q <= S_BS_DW;
				S_BS_DW: begin
					if (md_rsp.done) begin
						col_q <= col_q + CW'(1);
						state_q <= S_BS_CHK;
					end
				end
				// residual check, one equation at a time
				S_RS_ROW: begin
					if (i_q == n_q) begin
						state_q <= S_RS_FIN;
					end else begin
						sum_q <= 48'sd0;
						j_q <= '0;
						state_q <= S_RS_RD;
					end
				end
				S_RS_RD: state_q <= (j_q == m_q) ? S_RS_RHS : S_RS_MUL;
				S_RS_MUL: state_q <= S_RS_MW;
				S_RS_MW: begin
					if (md_rsp.done) begin
						sum_q <= sum_nx;
						j_q <= j_q + CW'(1);
						state_q <= S_RS_RD;
					end
				end
				S_RS_RHS: begin
					if (diff_mag > {33'd0, rtol_q}) begin
						status_q <= gjls_pkg::STATUS_NONE;
						col_q <= '0;
						state_q <= S_OUT_RD;
					end else begin
						i_q <= i_q + NW'(1);
						state_q <= S_RS_ROW;
					end
				end
				S_RS_FIN: begin
					status_q <= (|(~pv_q & m_mask)) ? gjls_pkg::STATUS_INFINITE
						: gjls_pkg::STATUS_UNIQUE;
					col_q <= '0;
					state_q <= S_OUT_RD;
				end
				S_OUT_RD: state_q <= S_OUT_EM;
				S_OUT_EM: begin
					if ((col_q + CW'(1)) == m_q) begin
						state_q <= S_IDLE;
					end else begin
						col_q <= col_q + CW'(1);
						state_q <= S_OUT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	gjls_ram #(.W(32), .D(DEPTH)) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(element_value),
		.raddr(cp_q),
		.rdata(st_rdata)
	);

	gjls_ram #(.W(48), .D(DEPTH)) u_work (
		.clk  (clk),
		.we   (w_we),
		.waddr(w_waddr),
		.wdata(w_wdata),
		.raddr(w_raddr),
		.rdata(w_rdata)
	);

	// per variable: pivot row and solution
	gjls_ram #(.W(XD_W), .D(MV)) u_aux (
		.clk  (clk),
		.we   (x_we),
		.waddr(x_waddr),
		.wdata(x_wdata),
		.raddr(x_raddr),
		.rdata(x_rdata)
	);

	gjls_muldiv u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.rsp   (md_rsp)
	);

	// present each result for one cycle
	assign result_valid = (state_q == S_OUT_EM);
	assign variable_index = 3'(col_q);
	assign solution_value = x_rdata[31:0];
	assign system_status = status_q;
	assign last_of_run = ((col_q + CW'(1)) == m_q);

	logic md_wait;
	assign md_wait = (state_q == S_EL_DW) || (state_q == S_EL_MW) || (state_q == S_BS_DW)
		|| (state_q == S_RS_MW);

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown while idle");

	a_solve_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && load_done) |=> (busy && !result_valid))
		else $error("final element did not start a solve");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_run) |=> (!result_valid && !busy))
		else $error("results continue after the last variable");

	a_md_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> md_wait)
		else $error("arithmetic result arrived outside a wait state");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import gjls_pkg::*;

	localparam int ROWS = 8;
	localparam int COLS = 9;
	localparam int ITEM_TARGET = 460;
	localparam int CYCLE_LIMIT = 1000000;
	localparam longint SAT_MAX = 64'sh0000_7FFF_FFFF_FFFF;

	// one directed request; want_* are only used where typed is set
	typedef struct packed {
		logic [2:0]  row;
		logic [3:0]  col;
		logic [31:0] value;
		logic        done;
		logic        typed;
		logic [31:0] want_value;
		logic [1:0]  want_status;
	} stim_t;

	// one awaited result
	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] value;
		logic [1:0]  status;
		logic        last;
	} solution_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  element_row;
	logic [3:0]  element_col;
	logic signed [31:0] element_value;
	logic        load_done;
	logic        result_valid;
	logic [2:0]  variable_index;
	logic signed [31:0] solution_value;
	logic [1:0]  system_status;
	logic        last_of_run;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	gauss_jordan_linear_solver_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.element_row(element_row), .element_col(element_col),
		.element_value(element_value), .load_done(load_done),
		.result_valid(result_valid), .variable_index(variable_index),
		.solution_value(solution_value), .system_status(system_status),
		.last_of_run(last_of_run), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the block's registers and loaded matrix
	logic [3:0]  eq_count_reg;
	logic [3:0]  var_count_reg;
	logic [15:0] pivot_tol_reg;
	logic [15:0] resid_tol_reg;
	longint      loaded [ROWS][COLS];
	bit          written [ROWS][COLS];
	longint      work [ROWS][COLS];
	logic signed [31:0] solved [ROWS];

	solution_t   pending_solutions [$];
	int          failures;
	int          sender_idle;
	int          items_sent;
	int          cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// the run is abandoned outright if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// fixed-point arithmetic of the solver, Q32.16 in 48 bits held in longint
	// ---------------------------------------------------------------
	function automatic longint clip48(longint v);
		if (v > SAT_MAX) return SAT_MAX;
		if (v < -SAT_MAX) return -SAT_MAX;
		return v;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// exact product, truncate toward zero, saturate
	function automatic longint times_q16(longint a, longint b);
		logic [127:0]    prod;
		longint unsigned r;
		bit              neg;
		neg = (a < 0) != (b < 0);
		prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		if (prod >= (128'd1 << 63)) begin
			r = SAT_MAX;
		end else begin
			r = prod[79:16];
		end
		if (r > SAT_MAX) r = SAT_MAX;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	// a divide by zero gives zero
	function automatic longint over_q16(longint a, longint b);
		longint unsigned q;
		bit              neg;
		neg = (a < 0) != (b < 0);
		if (magnitude(b) == 0) return 0;
		q = (magnitude(a) << 16) / magnitude(b);
		if (q > SAT_MAX) q = SAT_MAX;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// out-of-range counts saturate into 1..8 when the solve runs
	function automatic int used_count(logic [3:0] raw);
		if (raw == 0) return 1;
		return raw > 8 ? 8 : int'(raw);
	endfunction

	// ---------------------------------------------------------------
	// Gauss-Jordan elimination with partial pivoting; returns the status
	// ---------------------------------------------------------------
	function automatic logic [1:0] eliminate_and_classify();
		int      n, m, row, sel;
		bit      has_pivot [ROWS];
		int      pivot_row [ROWS];
		longint  best, factor, sum, diff, t;
		n = used_count(eq_count_reg);
		m = used_count(var_count_reg);
		row = 0;
		work = loaded;
		for (int i = 0; i < ROWS; i++) begin
			has_pivot[i] = 0;
			pivot_row[i] = 0;
		end
		for (int col = 0; col < m && row < n; col++) begin
			sel = row;
			for (int i = row; i < n; i++) begin
				if (magnitude(work[i][col]) > magnitude(work[sel][col])) sel = i;
			end
			best = magnitude(work[sel][col]);
			// a zero pivot is skipped even with a zero tolerance
			if (best == 0 || best < longint'(pivot_tol_reg)) continue;
			for (int j = col; j <= m; j++) begin
				t = work[sel][j];
				work[sel][j] = work[row][j];
				work[row][j] = t;
			end
			has_pivot[col] = 1;
			pivot_row[col] = row;
			for (int i = 0; i < n; i++) begin
				if (i == row) continue;
				factor = over_q16(work[i][col], work[row][col]);
				for (int j = col; j <= m; j++) begin
					work[i][j] = clip48(work[i][j] - times_q16(work[row][j], factor));
				end
			end
			row++;
		end
		// free variables stay at zero
		for (int i = 0; i < ROWS; i++) solved[i] = 0;
		for (int i = 0; i < m; i++) begin
			if (has_pivot[i]) begin
				solved[i] = clip32(over_q16(work[pivot_row[i]][m], work[pivot_row[i]][i]));
			end
		end
		for (int i = 0; i < n; i++) begin
			sum = 0;
			for (int j = 0; j < m; j++) begin
				sum = clip48(sum + times_q16(longint'(solved[j]), work[i][j]));
			end
			diff = sum - work[i][m];
			if (magnitude(diff) > longint'(resid_tol_reg)) return STATUS_NONE;
		end
		for (int i = 0; i < m; i++) begin
			if (!has_pivot[i]) return STATUS_INFINITE;
		end
		return STATUS_UNIQUE;
	endfunction

	// queue one result per variable
	task automatic predict_solutions();
		logic [1:0] status;
		solution_t  s;
		int         m;
		status = eliminate_and_classify();
		m = used_count(var_count_reg);
		for (int i = 0; i < m; i++) begin
			s.index = i[2:0];
			s.value = solved[i];
			s.status = status;
			s.last = (i + 1 == m);
			pending_solutions.push_back(s);
		end
	endtask

	// ---------------------------------------------------------------
	// result checker: the receiver takes every request as it comes
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_solutions.size() == 0) begin
				$display("%0t: unexpected result index %0d value %h status %0d",
					$time, variable_index, solution_value, system_status);
				failures++;
			end else begin
				solution_t w;
				w = pending_solutions.pop_front();
				if (variable_index !== w.index) begin
					$display("%0t: variable_index expected %0d actual %0d",
						$time, w.index, variable_index);
					failures++;
				end
				if (solution_value !== w.value) begin
					$display("%0t: solution_value (index %0d) expected %h actual %h",
						$time, w.index, w.value, solution_value);
					failures++;
				end
				if (system_status !== w.status) begin
					$display("%0t: system_status (index %0d) expected %0d actual %0d",
						$time, w.index, w.status, system_status);
					failures++;
				end
				if (last_of_run !== w.last) begin
					$display("%0t: last_of_run (index %0d) expected %0d actual %0d",
						$time, w.index, w.last, last_of_run);
					failures++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus tasks
	// ---------------------------------------------------------------

	// hold the request until accepted, then advance the shadow matrix
	task automatic send_element(logic [2:0] row, logic [3:0] col, logic [31:0] value,
			logic done, logic typed, logic [31:0] want_value, logic [1:0] want_status);
		solution_t s;
		while ($urandom_range(99) < sender_idle) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		element_row <= row;
		element_col <= col;
		element_value <= value;
		load_done <= done;
		do @(posedge clk); while (busy);
		// columns above the right-hand side limit are dropped by the block
		if (col <= 8) begin
			loaded[row][col] = longint'(signed'(value));
			written[row][col] = 1;
		end
		if (done) begin
			if (typed) begin
				s.index = 3'd0;
				s.value = want_value;
				s.status = want_status;
				s.last = 1'b1;
				pending_solutions.push_back(s);
			end else begin
				predict_solutions();
			end
		end
	endtask

	// drop start and wait until every awaited result has arrived
	task automatic drain();
		start <= 1'b0;
		while (pending_solutions.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] index, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			REG_NUM_EQUATIONS: eq_count_reg = data[3:0];
			REG_NUM_VARIABLES: var_count_reg = data[3:0];
			REG_PIVOT_TOL:     pivot_tol_reg = data;
			default:           resid_tol_reg = data;
		endcase
	endtask

	task automatic configure(logic [15:0] eqs, logic [15:0] vars, logic [15:0] ptol,
			logic [15:0] rtol);
		drain();
		write_register(REG_NUM_EQUATIONS, eqs);
		write_register(REG_NUM_VARIABLES, vars);
		write_register(REG_PIVOT_TOL, ptol);
		write_register(REG_RESIDUAL_TOL, rtol);
	endtask

	// mostly small systems, now and then the full size or an out-of-range count
	function automatic logic [15:0] pick_count();
		int r;
		r = $urandom_range(19);
		if (r == 0) return {$urandom_range(4095), 4'd0};
		if (r == 1) return 16'($urandom_range(15, 9)) | ($urandom_range(1) << 8);
		if (r == 2) return 16'd8;
		return 16'($urandom_range(3, 1));
	endfunction

	function automatic logic [15:0] pick_tolerance();
		case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'd1;
			3: return 16'd64;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] random_value();
		case ($urandom_range(9))
			0, 1: return 32'($urandom);
			2:    return 32'd0;
			3:    return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			4, 5: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
			default: return 32'(($signed($urandom_range(16)) - 8) <<< 16);
		endcase
	endfunction

	// load one system and solve it; returns the number of counted elements
	task automatic run_system(output int counted);
		int          n, m, kind, cnt, dup;
		int          solution [COLS];
		logic [31:0] values [ROWS][COLS];
		logic [2:0]  rows_q [$];
		logic [3:0]  cols_q [$];
		longint      rhs;
		n = used_count(eq_count_reg);
		m = used_count(var_count_reg);
		kind = $urandom_range(99);
		dup = $urandom_range(n - 1);
		for (int j = 0; j < m; j++) solution[j] = $signed($urandom_range(6)) - 3;
		// build the content: random, consistent with an integer answer,
		// or consistent with a repeated equation
		for (int i = 0; i < n; i++) begin
			rhs = 0;
			for (int j = 0; j < m; j++) begin
				if (kind < 30) begin
					values[i][j] = random_value();
				end else if (kind >= 75 && i == dup && i != 0) begin
					values[i][j] = values[0][j];
				end else begin
					values[i][j] = 32'(($signed($urandom_range(8)) - 4) <<< 16);
				end
				rhs += longint'(signed'(values[i][j])) * solution[j];
			end
			values[i][m] = kind < 30 ? random_value() : rhs[31:0];
			for (int j = 0; j <= m; j++) begin
				if (kind >= 30 || !written[i][j] || $urandom_range(3) == 0) begin
					rows_q.push_back(i[2:0]);
					cols_q.push_back(j[3:0]);
				end
			end
		end
		if (rows_q.size() == 0) begin
			rows_q.push_back(3'd0);
			cols_q.push_back(4'd0);
		end
		// scramble the loading order
		for (int k = rows_q.size() - 1; k > 0; k--) begin
			int      r;
			logic [2:0] tr;
			logic [3:0] tc;
			r = $urandom_range(k);
			tr = rows_q[k]; rows_q[k] = rows_q[r]; rows_q[r] = tr;
			tc = cols_q[k]; cols_q[k] = cols_q[r]; cols_q[r] = tc;
		end
		cnt = 0;
		foreach (rows_q[k]) begin
			// noise: out-of-range columns and rows the solve does not use
			if ($urandom_range(15) == 0) begin
				send_element(3'($urandom), 4'($urandom_range(15, 9)), 32'($urandom),
					1'b0, 1'b0, 32'd0, STATUS_NONE);
			end
			if ($urandom_range(15) == 0 && n < ROWS) begin
				send_element(3'($urandom_range(7, n)), 4'($urandom_range(8)), random_value(),
					1'b0, 1'b0, 32'd0, STATUS_NONE);
			end
			send_element(rows_q[k], cols_q[k], values[rows_q[k]][cols_q[k]],
				k == rows_q.size() - 1, 1'b0, 32'd0, STATUS_NONE);
			cnt++;
		end
		counted = cnt;
	endtask

	// ---------------------------------------------------------------
	// directed requests, all on a one-by-one system
	// ---------------------------------------------------------------
	stim_t plan [18];

	initial begin
		int got;
		int phase_idle [3];

		start = 1'b0;
		element_row = 3'd0;
		element_col = 4'd0;
		element_value = 32'sd0;
		load_done = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_NUM_EQUATIONS;
		cfg_data = 16'd0;
		failures = 0;
		items_sent = 0;
		cycles = 0;
		sender_idle = 0;
		eq_count_reg = 4'd4;
		var_count_reg = 4'd3;
		pivot_tol_reg = 16'd1;
		resid_tol_reg = 16'd64;
		for (int i = 0; i < ROWS; i++) begin
			for (int j = 0; j < COLS; j++) begin
				loaded[i][j] = 0;
				written[i][j] = 0;
			end
		end

		plan = '{
			// 2x = 4 gives x = 2
			'{3'd0, 4'd0, 32'h0002_0000, 1'b0, 1'b0, 32'd0, STATUS_NONE},
			'{3'd0, 4'd1, 32'h0004_0000, 1'b1, 1'b1, 32'h0002_0000, STATUS_UNIQUE},
			// 0x = 4 has no solution, the free variable reads zero
			'{3'd0, 4'd0, 32'h0000_0000, 1'b1, 1'b1, 32'd0, STATUS_NONE},
			// 0x = 0 leaves x free
			'{3'd0, 4'd1, 32'h0000_0000, 1'b1, 1'b1, 32'd0, STATUS_INFINITE},
			// out-of-range columns are ignored, column 8 is stored but unused
			'{3'd0, 4'd9, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, STATUS_NONE},
			'{3'd0, 4'd15, 32'h1234_5678, 1'b0, 1'b0, 32'd0, STATUS_NONE},
			'{3'd0, 4'd8, 32'h0000_007B, 1'b0, 1'b0, 32'd0, STATUS_NONE},
			'{3'd7, 4'd3, 32'h0000_0005, 1'b0, 1'b0, 32'd0, STATUS_NONE},
			// most negative over most negative is one
			'{3'd0, 4'd0, 32'h8000_0000, 1'b0, 1'b0, 32'd0, STATUS_NONE},
			'{3'd0, 4'd1, 32'h8000_0000, 1'b1, 1'b1, 32'h0001_0000, STATUS_UNIQUE},
			// extremes of opposite sign
			'{3'd0, 4'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0, STATUS_NONE},
			'{3'd0, 4'd1, 32'h8000_0000, 1'b1, 1'b0, 32'd0, STATUS_NONE},
			// tiny pivot: the quotient saturates
			'{3'd0, 4'd0, 32'h0000_0001, 1'b0, 1'b0, 32'd0, STATUS_NONE},
			'{3'd0, 4'd1, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'd0, STATUS_NONE},
			// pivot exactly at the tolerance is kept
			'{3'd0, 4'd1, 32'h0000_0001, 1'b1, 1'b1, 32'h0001_0000, STATUS_UNIQUE},
			// alternating bit patterns
			'{3'd0, 4'd0, 32'h5555_5555, 1'b0, 1'b0, 32'd0, STATUS_NONE},
			'{3'd0, 4'd1, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'd0, STATUS_NONE},
			'{3'd0, 4'd0, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'd0, STATUS_NONE}
		};

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(16'd1, 16'd1, 16'd1, 16'd64);
		foreach (plan[k]) begin
			send_element(plan[k].row, plan[k].col, plan[k].value, plan[k].done,
				plan[k].typed, plan[k].want_value, plan[k].want_status);
		end

		// random systems in three idling phases, the first two opened by an extreme setting
		phase_idle = '{31, 81, 0};
		for (int p = 0; p < 3; p++) begin
			sender_idle = phase_idle[p];
			case (p)
				0: configure(16'd8, 16'd8, 16'd0, 16'hFFFF);
				1: configure(16'd0, 16'd15, 16'hFFFF, 16'd0);
				default: configure(16'd2, 16'd2, 16'd1, 16'd64);
			endcase
			while (items_sent < ITEM_TARGET * (p + 1) / 3) begin
				if ($urandom_range(2) == 0) begin
					configure(pick_count(), pick_count(), pick_tolerance(),
						pick_tolerance());
				end else if ($urandom_range(9) == 0) begin
					// hold off until the block has delivered everything
					drain();
				end
				run_system(got);
				items_sent += got;
			end
		end

		start <= 1'b0;
		while (pending_solutions.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (failures == 0 && pending_solutions.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gjls_pkg.sv
rtl/gjls_ram.sv
rtl/gjls_muldiv.sv
rtl/gauss_jordan_linear_solver_unit.sv
sim/testbench.sv
